// ----- src/assert_macros.svh -----
// Assertion macros used by the path canonicaliser stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- src/pcan_pkg.sv -----
// Shared constants and types for the path canonicaliser.
package pcan_pkg;

    localparam int DEFAULT_MAX_PATH_LEN = 4096;

    // Fixed field widths of the channels
    localparam int RIDX_W = 12;
    localparam int PLEN_W = 13;

    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    // Opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_ABS  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_PAST_END = 2'd3;

    // Dot counter: 1 and 2 mean "." and ".." so far, this code means a real name
    localparam logic [1:0] DOT_NAME = 2'd3;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } pcan_stack_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pcan_stack_flags_t;

endpackage

// ----- src/pcan_stack.sv -----
// Component start stack: cached top entry in a register, lower entries in a memory.
`include "assert_macros.svh"

module pcan_stack
    import pcan_pkg::*;
#(
    parameter int MAX_PATH_LEN = DEFAULT_MAX_PATH_LEN,
    parameter int LEN_W        = $clog2(MAX_PATH_LEN + 2)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pcan_stack_cmd_t   cmd,
    input  logic [LEN_W-1:0]  push_data,
    output logic [LEN_W-1:0]  top,
    output pcan_stack_flags_t flags
);

    localparam int STACK_SIZE = MAX_PATH_LEN / 2 + 1;
    localparam int MEM_DEPTH  = MAX_PATH_LEN / 2;
    localparam int SIDX_W     = $clog2(MEM_DEPTH);
    localparam int DEPTH_W    = $clog2(STACK_SIZE + 1);

    logic [LEN_W-1:0]   start_mem [MEM_DEPTH];
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [LEN_W-1:0]   top_reg;
    logic [LEN_W-1:0]   fill_reg;
    logic               pend_reg;
    logic               pend_next;
    logic [SIDX_W-1:0]  wr_idx;
    logic [SIDX_W-1:0]  rd_idx;
    logic               mem_we;
    logic               mem_re;

    // After a pop the new top is loaded from memory into the fill register; until
    // the next push or clear it is served from the fill register.
    assign top         = pend_reg ? fill_reg : top_reg;
    assign flags.empty = (depth_reg == '0);
    assign flags.full  = (depth_reg == DEPTH_W'(STACK_SIZE));

    assign wr_idx = SIDX_W'(depth_reg - DEPTH_W'(1));
    assign rd_idx = SIDX_W'(depth_reg - DEPTH_W'(2));
    assign mem_we = cmd.push && !cmd.clear && (depth_reg != '0);
    assign mem_re = cmd.pop && !cmd.clear && (depth_reg >= DEPTH_W'(2));

    always_comb begin
        depth_next = depth_reg;
        pend_next  = pend_reg;
        priority if (cmd.clear) begin
            depth_next = '0;
            pend_next  = 1'b0;
        end else if (cmd.push) begin
            depth_next = depth_reg + DEPTH_W'(1);
            pend_next  = 1'b0;
        end else if (cmd.pop) begin
            depth_next = depth_reg - DEPTH_W'(1);
            pend_next  = 1'b1;
        end else begin
            depth_next = depth_reg;
            pend_next  = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && !cmd.clear) begin
            top_reg <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            start_mem[wr_idx] <= top;
        end
        if (mem_re) begin
            fill_reg <= start_mem[rd_idx];
        end
    end

    `ASSERT_NEVER(a_push_full, cmd.push && flags.full, "push onto full stack")
    `ASSERT_NEVER(a_pop_empty, cmd.pop && flags.empty, "pop from empty stack")
    `ASSERT_NEVER(a_push_pop, cmd.push && cmd.pop, "push and pop together")
    `ASSERT_PROP(a_pop_pend, (cmd.pop && !cmd.clear) |=> pend_reg, "pop left no fill")
    `ASSERT_PROP(a_push_top, (cmd.push && !cmd.clear) |=> (!pend_reg && top == $past(push_data)), "push lost top")

endmodule

// ----- src/path_canonicalizer_top.sv -----
// Path canonicaliser top level: byte stream in, canonical path store, results out.
//
// Canonicalises an absolute Unix path fed one byte per transfer (opcode 0, with
// s_last on the final byte) into an internal store, dropping empty and "."
// components and resolving ".." against a stack of component start offsets.
// A final byte gives one result: status (ok, not absolute, too long) and the
// canonical length, where an empty result is the root "/" of length 1. A read
// transfer (opcode 1) returns the stored byte at s_read_index, or status "past
// end" if the index is at or beyond the length; reads part-way through a path
// see the partial result. Other path bytes give no result. The block takes one
// transfer per clock while s_ready is high: every byte is at most one store
// write plus one stack push or pop, and the stack keeps its top entry in a
// register so that a pop needs no memory read on the critical path. Results
// appear in an output register in the cycle after the input transfer; s_ready
// is low only while that register holds a result that is not being taken. There
// is no clearing pass after reset. Store bytes are only defined once written,
// which the length bookkeeping guarantees for every index a read can reach.
module path_canonicalizer_top
    import pcan_pkg::*;
#(
    parameter int MAX_PATH_LEN = DEFAULT_MAX_PATH_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [7:0]        s_char_byte,
    input  logic              s_last,
    input  logic [RIDX_W-1:0] s_read_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [PLEN_W-1:0] m_path_length,
    output logic [7:0]        m_out_byte
);

    localparam int LEN_W  = $clog2(MAX_PATH_LEN + 2);
    localparam int ADDR_W = $clog2(MAX_PATH_LEN);
    localparam int CMP_W  = (LEN_W > RIDX_W) ? LEN_W : RIDX_W;
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PATH_LEN);
    localparam logic [LEN_W:0]   MAX_LEN1 = (LEN_W + 1)'(MAX_PATH_LEN);

    // Path state
    logic [LEN_W-1:0] bc_reg, bc_next;       // bytes of current path, saturating
    logic [LEN_W-1:0] wl_reg, wl_next;       // canonical length so far
    logic [LEN_W-1:0] clen_reg, clen_next;   // length of open component
    logic [1:0]       dot_reg, dot_next;
    logic             not_abs_reg, not_abs_next;
    logic             too_long_reg, too_long_next;

    // Output stage
    logic              m_valid_reg;
    logic [1:0]        status_reg;
    logic [PLEN_W-1:0] len_reg;
    logic              from_store_reg;
    logic [7:0]        byte_const_reg;
    logic [7:0]        store_q_reg;

    // Store and stack hookup
    logic [7:0]        path_store [MAX_PATH_LEN];
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [7:0]        st_wdata;
    logic              st_re;
    pcan_stack_cmd_t   stk_cmd;
    pcan_stack_flags_t stk_flags;
    logic [LEN_W-1:0]  stk_top;
    logic [LEN_W-1:0]  stk_push_data;

    // Combinational working values
    logic             in_xfer, byte_xfer, read_xfer, res_fire;
    logic             first, skip, live, is_slash, do_end, notabs_c, too_long_c;
    logic             empty_c, full_c, drop, dotdot;
    logic [LEN_W-1:0] wl_c, clen_c, clen_u, wl_e, bc_inc;
    logic [1:0]       dot_c, dot_u;
    logic [LEN_W:0]   pos, grow;
    logic [LEN_W-1:0] vis_len, fin_len;
    logic             past_end;
    logic [1:0]       res_status;
    logic [PLEN_W-1:0] res_len;
    logic             res_from_store;
    logic [7:0]       res_byte;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;
    assign byte_xfer = in_xfer && (s_opcode == OP_BYTE);
    assign read_xfer = in_xfer && (s_opcode == OP_READ);
    assign res_fire  = read_xfer || (byte_xfer && s_last);

    always_comb begin
        // The first byte of a path sees freshly cleared state
        first      = (bc_reg == '0);
        wl_c       = first ? '0 : wl_reg;
        clen_c     = first ? '0 : clen_reg;
        dot_c      = first ? '0 : dot_reg;
        notabs_c   = first ? (s_char_byte != SLASH_CHAR) : not_abs_reg;
        empty_c    = first || stk_flags.empty;
        full_c     = !first && stk_flags.full;

        skip       = (bc_reg >= MAX_LEN);
        bc_inc     = (bc_reg <= MAX_LEN) ? bc_reg + LEN_W'(1) : bc_reg;
        too_long_c = (!first && too_long_reg) || skip;
        is_slash   = (s_char_byte == SLASH_CHAR);
        live       = !skip && !notabs_c;

        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = SLASH_CHAR;

        // Name byte: extend the open component
        clen_u = clen_c;
        dot_u  = dot_c;
        pos    = (LEN_W + 1)'(wl_c) + (LEN_W + 1)'(clen_c) + (LEN_W + 1)'(1);
        if (live && !is_slash) begin
            clen_u = (clen_c < MAX_LEN) ? clen_c + LEN_W'(1) : clen_c;
            dot_u  = ((s_char_byte == DOT_CHAR) && (dot_c < 2'd2)) ? dot_c + 2'd1
                                                                    : DOT_NAME;
            if (pos < MAX_LEN1) begin
                st_we    = byte_xfer;
                st_waddr = ADDR_W'(pos);
                st_wdata = s_char_byte;
            end
        end

        // End of component, at a slash or at the implied slash after the last byte
        do_end = (live && is_slash) || (s_last && !notabs_c);
        drop   = (clen_u == '0) || ((clen_u == LEN_W'(1)) && (dot_u == 2'd1));
        dotdot = (clen_u == LEN_W'(2)) && (dot_u == 2'd2);
        grow   = (LEN_W + 1)'(wl_c) + (LEN_W + 1)'(clen_u) + (LEN_W + 1)'(1);
        wl_e          = wl_c;
        stk_cmd.push  = 1'b0;
        stk_cmd.pop   = 1'b0;
        stk_push_data = wl_c;
        if (do_end) begin
            priority if (drop) begin
                wl_e = wl_c;
            end else if (dotdot) begin
                if (!empty_c) begin
                    stk_cmd.pop = byte_xfer;
                    wl_e        = stk_top;
                end
            end else if (!full_c) begin
                stk_cmd.push = byte_xfer;
                wl_e         = (grow > MAX_LEN1) ? MAX_LEN : LEN_W'(grow);
            end else begin
                wl_e = wl_c;
            end
        end
        stk_cmd.clear = byte_xfer && (first || (s_last && notabs_c));

        // A slash pre-writes the separator of the next component at the new end
        if (live && is_slash && ((LEN_W + 1)'(wl_e) < MAX_LEN1)) begin
            st_we    = byte_xfer;
            st_waddr = ADDR_W'(wl_e);
            st_wdata = SLASH_CHAR;
        end

        // Next state
        bc_next       = bc_reg;
        wl_next       = wl_reg;
        clen_next     = clen_reg;
        dot_next      = dot_reg;
        not_abs_next  = not_abs_reg;
        too_long_next = too_long_reg;
        if (byte_xfer) begin
            bc_next       = s_last ? '0 : bc_inc;
            wl_next       = (s_last && notabs_c) ? '0 : wl_e;
            clen_next     = (s_last || do_end) ? '0 : clen_u;
            dot_next      = (s_last || do_end) ? '0 : dot_u;
            not_abs_next  = s_last ? 1'b0 : notabs_c;
            too_long_next = s_last ? 1'b0 : too_long_c;
        end

        // Result
        vis_len  = (wl_reg == '0) ? LEN_W'(1) : wl_reg;
        fin_len  = (wl_next == '0) ? LEN_W'(1) : wl_next;
        past_end = (CMP_W'(s_read_index) >= CMP_W'(vis_len));
        st_re    = 1'b0;
        res_from_store = 1'b0;
        res_byte       = 8'h00;
        if (s_opcode == OP_READ) begin
            res_len = PLEN_W'(vis_len);
            if (past_end) begin
                res_status = ST_PAST_END;
            end else begin
                res_status = ST_OK;
                if (wl_reg == '0) begin
                    res_byte = SLASH_CHAR;
                end else begin
                    res_from_store = 1'b1;
                    st_re          = read_xfer;
                end
            end
        end else begin
            res_len = PLEN_W'(fin_len);
            priority if (notabs_c) begin
                res_status = ST_NOT_ABS;
            end else if (too_long_c) begin
                res_status = ST_TOO_LONG;
            end else begin
                res_status = ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg       <= '0;
            wl_reg       <= '0;
            clen_reg     <= '0;
            dot_reg      <= '0;
            not_abs_reg  <= 1'b0;
            too_long_reg <= 1'b0;
        end else begin
            bc_reg       <= bc_next;
            wl_reg       <= wl_next;
            clen_reg     <= clen_next;
            dot_reg      <= dot_next;
            not_abs_reg  <= not_abs_next;
            too_long_reg <= too_long_next;
        end
    end

    // Path store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (st_we) begin
            path_store[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            store_q_reg <= path_store[ADDR_W'(s_read_index)];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= res_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            status_reg     <= res_status;
            len_reg        <= res_len;
            from_store_reg <= res_from_store;
            byte_const_reg <= res_byte;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_path_length = len_reg;
    assign m_out_byte    = from_store_reg ? store_q_reg : byte_const_reg;

    pcan_stack #(
        .MAX_PATH_LEN (MAX_PATH_LEN),
        .LEN_W        (LEN_W)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (stk_cmd),
        .push_data (stk_push_data),
        .top       (stk_top),
        .flags     (stk_flags)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the path canonicaliser: directed and random paths with reads.
`timescale 1ns / 100ps

module testbench;
    import pcan_pkg::*;

    // Path store depth and the depth of the component-start stack behind it
    localparam int MAX_LEN     = DEFAULT_MAX_PATH_LEN;
    localparam int STACK_DEPTH = MAX_LEN / 2 + 1;
    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 9;
    // Well above the slowest legal run, with both sides idling
    localparam int CYCLE_LIMIT = 400000;
    // Random transfers per idle pattern
    localparam int PHASE_ITEMS = 450;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [1:0]        status;
        logic [PLEN_W-1:0] length;
        logic [7:0]        out_byte;
    } canon_result_t;

    // Scoreboard: keeps its own copy of the canonical path and predicts every result
    class path_scoreboard;
        logic [7:0]        canon_bytes [MAX_LEN];
        logic [PLEN_W-1:0] seg_starts [STACK_DEPTH];
        logic [11:0]       seg_depth;
        logic [PLEN_W-1:0] canon_len;
        logic [PLEN_W-1:0] seg_len;
        logic [PLEN_W-1:0] bytes_seen;
        logic [1:0]        dot_run;
        bit                err_not_abs;
        bit                err_too_long;
        canon_result_t     pending[$];
        int                errors;
        int                checked;

        function new();
            foreach (canon_bytes[i]) canon_bytes[i] = 8'h00;
            foreach (seg_starts[i]) seg_starts[i] = '0;
            seg_depth    = '0;
            canon_len    = '0;
            seg_len      = '0;
            bytes_seen   = '0;
            dot_run      = '0;
            err_not_abs  = 1'b0;
            err_too_long = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        function logic [PLEN_W-1:0] shown_length();
            return (canon_len == 0) ? PLEN_W'(1) : canon_len;
        endfunction

        function void queue_result(logic [1:0] st, logic [PLEN_W-1:0] len, logic [7:0] ob);
            canon_result_t r;
            r.status   = st;
            r.length   = len;
            r.out_byte = ob;
            pending.push_back(r);
        endfunction

        // Evaluate the component that a slash (real or implied) has just closed
        function void close_component();
            int unsigned grown;
            bit          dropped;
            bit          go_up;
            dropped = (seg_len == 0) || (seg_len == 1 && dot_run == 2'd1);
            go_up   = (seg_len == 2 && dot_run == 2'd2);
            if (go_up) begin
                if (seg_depth > 0) begin
                    seg_depth = seg_depth - 1'b1;
                    canon_len = seg_starts[seg_depth];
                end
            end else if (!dropped && seg_depth < STACK_DEPTH) begin
                grown = canon_len + 1 + seg_len;
                seg_starts[seg_depth] = canon_len;
                seg_depth = seg_depth + 1'b1;
                if (canon_len < MAX_LEN)
                    canon_bytes[canon_len] = SLASH_CHAR;
                canon_len = (grown > MAX_LEN) ? PLEN_W'(MAX_LEN) : PLEN_W'(grown);
            end
            seg_len = '0;
            dot_run = '0;
        endfunction

        // Called for every accepted input transfer, in order
        function void note_transfer(logic op, logic [7:0] ch, logic lst, logic [RIDX_W-1:0] idx);
            int unsigned       pos;
            logic [PLEN_W-1:0] vis;
            if (op == OP_READ) begin
                vis = shown_length();
                if (idx >= vis)
                    queue_result(ST_PAST_END, vis, 8'h00);
                else if (canon_len == 0)
                    queue_result(ST_OK, vis, SLASH_CHAR);
                else
                    queue_result(ST_OK, vis, canon_bytes[idx]);
                return;
            end
            if (bytes_seen == 0) begin
                canon_len    = '0;
                seg_depth    = '0;
                seg_len      = '0;
                dot_run      = '0;
                err_too_long = 1'b0;
                err_not_abs  = (ch != SLASH_CHAR);
            end
            if (bytes_seen <= MAX_LEN)
                bytes_seen = bytes_seen + 1'b1;
            if (bytes_seen > MAX_LEN) begin
                err_too_long = 1'b1;
            end else if (!err_not_abs) begin
                if (ch == SLASH_CHAR) begin
                    close_component();
                end else begin
                    pos = canon_len + 1 + seg_len;
                    if (pos < MAX_LEN)
                        canon_bytes[pos] = ch;
                    if (seg_len < MAX_LEN)
                        seg_len = seg_len + 1'b1;
                    if (ch == DOT_CHAR && dot_run < 2'd2)
                        dot_run = dot_run + 1'b1;
                    else
                        dot_run = DOT_NAME;
                end
            end
            if (!lst)
                return;
            if (err_not_abs) begin
                canon_len = '0;
                seg_depth = '0;
                queue_result(ST_NOT_ABS, shown_length(), 8'h00);
            end else begin
                close_component();
                queue_result(err_too_long ? ST_TOO_LONG : ST_OK, shown_length(), 8'h00);
            end
            bytes_seen   = '0;
            seg_len      = '0;
            dot_run      = '0;
            err_not_abs  = 1'b0;
            err_too_long = 1'b0;
        endfunction

        // Called for every accepted result transfer
        function void check_result(logic [1:0] st, logic [PLEN_W-1:0] len, logic [7:0] ob);
            canon_result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, status %0d length %0d byte %h",
                         $time, st, len, ob);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (st !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, st);
            end
            if (len !== want.length) begin
                errors++;
                $display("%0t: path_length mismatch, expected %0d, actual %0d",
                         $time, want.length, len);
            end
            if (ob !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte mismatch, expected %h, actual %h",
                         $time, want.out_byte, ob);
            end
        endfunction
    endclass

    // Every block input starts at a known value
    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_opcode     = OP_BYTE;
    logic [7:0]        s_char_byte  = 8'h00;
    logic              s_last       = 1'b0;
    logic [RIDX_W-1:0] s_read_index = '0;
    logic              m_ready      = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [1:0]        m_status;
    logic [PLEN_W-1:0] m_path_length;
    logic [7:0]        m_out_byte;

    path_scoreboard sb;
    int  idle_send_pct = 0;    // chance per cycle that the sender holds off
    int  stall_pct     = 0;    // chance per cycle that the receiver stalls
    int  read_mix_pct  = 0;    // chance of a read slipped in after a path byte
    int  items_sent    = 0;
    int  cycles        = 0;

    path_canonicalizer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_char_byte   (s_char_byte),
        .s_last        (s_last),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_path_length (m_path_length),
        .m_out_byte    (m_out_byte)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Run guard: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycles, sb.pending.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure; one assignment per edge
    always @(posedge aclk) begin
        m_ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    // Monitor. Inputs change only just after a rising edge, so at the falling edge
    // valid/ready show exactly what the next rising edge will transfer. Input is
    // noted before the result check so that a same-cycle result would still match.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_transfer(s_opcode, s_char_byte, s_last, s_read_index);
            if (m_valid && m_ready)
                sb.check_result(m_status, m_path_length, m_out_byte);
        end
    end

    // One input transfer. Entered and left just after a rising edge; valid stays
    // high straight into the next transfer unless the sender decides to idle.
    task automatic send_item(logic op, logic [7:0] ch, logic lst, logic [RIDX_W-1:0] idx);
        if (idle_send_pct != 0 && $urandom_range(99) < idle_send_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_send_pct);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_char_byte  <= ch;
        s_last       <= lst;
        s_read_index <= idx;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    // Fields that the opcode ignores carry random values
    task automatic send_read(logic [RIDX_W-1:0] idx);
        send_item(OP_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    task automatic send_byte(logic [7:0] ch);
        send_item(OP_BYTE, ch, 1'b0, RIDX_W'($urandom));
    endtask

    // Mostly inside the current result, sometimes just past it or anywhere
    task automatic random_read();
        logic [PLEN_W-1:0] vis;
        int                pick;
        vis  = sb.shown_length();
        pick = $urandom_range(9);
        if (pick < 7)
            send_read(RIDX_W'($urandom_range(vis - 1)));
        else if (pick == 7)
            send_read(RIDX_W'((vis >= MAX_LEN) ? MAX_LEN - 1 : vis));
        else
            send_read(RIDX_W'($urandom_range(MAX_LEN - 1)));
    endtask

    task automatic send_path(byte_q_t q);
        for (int i = 0; i < q.size(); i++) begin
            send_item(OP_BYTE, q[i], i == q.size() - 1, RIDX_W'($urandom));
            if (i != q.size() - 1 && read_mix_pct != 0 && $urandom_range(99) < read_mix_pct)
                random_read();
        end
    endtask

    function automatic byte_q_t text_bytes(string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // Any name byte: letters, dots, and the rest of the byte range bar the slash
    function automatic logic [7:0] name_char();
        int          pick;
        logic [7:0]  c;
        pick = $urandom_range(9);
        if (pick < 6)
            return 8'("a") + 8'($urandom_range(25));
        if (pick < 8)
            return DOT_CHAR;
        c = 8'($urandom_range(255));
        return (c == SLASH_CHAR) ? DOT_CHAR : c;
    endfunction

    // Mostly well-formed absolute paths made of empty, ".", ".." and named components,
    // with a few relative paths and a little pure noise
    task automatic send_random_path();
        byte_q_t q;
        int      pick;
        int      n_segs;
        int      n_reads;
        int      name_len;
        pick = $urandom_range(99);
        if (pick < 5) begin
            n_segs = $urandom_range(1, 12);
            for (int i = 0; i < n_segs; i++) begin
                if ($urandom_range(2) == 0)
                    q.push_back(SLASH_CHAR);
                else
                    q.push_back(8'($urandom_range(255)));
            end
        end else begin
            if (pick < 13) begin
                q.push_back(name_char());
                if (q[0] == SLASH_CHAR)
                    q[0] = DOT_CHAR;
            end
            n_segs = $urandom_range(0, 6);
            for (int k = 0; k < n_segs; k++) begin
                q.push_back(SLASH_CHAR);
                if ($urandom_range(9) == 0)
                    q.push_back(SLASH_CHAR);
                case ($urandom_range(9))
                    0, 1: q.push_back(DOT_CHAR);
                    2, 3, 4: begin
                        q.push_back(DOT_CHAR);
                        q.push_back(DOT_CHAR);
                    end
                    5: ;
                    default: begin
                        name_len = $urandom_range(1, 6);
                        for (int j = 0; j < name_len; j++)
                            q.push_back(name_char());
                    end
                endcase
            end
            if (q.size() == 0 || $urandom_range(3) == 0)
                q.push_back(SLASH_CHAR);
        end
        send_path(q);
        n_reads = $urandom_range(0, 3);
        repeat (n_reads) random_read();
    endtask

    initial begin
        byte_q_t q;
        int      phase_start;
        sb = new();

        // Synchronous reset, asserted once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: root after reset, read past the end at the top index
        send_read('0);
        send_read(RIDX_W'(MAX_LEN - 1));
        // Bare root, then a relative path
        send_path(text_bytes("/"));
        send_path(text_bytes("x/"));
        // ".." at the root, an all-ones name, "." dropped, ".." back to the root
        q = text_bytes("/../?/./..");
        q[4] = 8'hFF;
        send_path(q);
        // Zero byte as a name, an empty component, "..." kept as a name,
        // and a read part-way through the path
        send_byte(SLASH_CHAR);
        send_byte(8'h00);
        send_byte(SLASH_CHAR);
        send_read(RIDX_W'(1));
        send_byte(SLASH_CHAR);
        send_path(text_bytes("..."));
        send_read(RIDX_W'(5));
        send_read(RIDX_W'(6));

        // Random part under four idle patterns
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_send_pct = 0;  stall_pct = 0;  end
                1: begin idle_send_pct = 49; stall_pct = 0;  end
                2: begin idle_send_pct = 0;  stall_pct = 49; end
                default: begin idle_send_pct = 28; stall_pct = 28; end
            endcase
            read_mix_pct = 12;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_path();
        end
        s_valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d transfers across four idle patterns; %0d results checked.",
                 items_sent, sb.checked);
        $display("Covered dot handling, relative paths, reads mid-path and out-of-range reads.");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/pcan_pkg.sv
src/pcan_stack.sv
src/path_canonicalizer_top.sv
tb/testbench.sv
